// ===== rtl/madg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madg_pkg
// Shared types and constants of the array address generator: stream field
// layout, command codes and the descriptor entry formats.
// ----------------------------------------------------------------------------
package madg_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int AID_W   = 4;
    localparam int BASE_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int DCNT_W  = 5;
    localparam int DSEL_W  = 4;
    localparam int BOUND_W = 32;
    localparam int IDX_W   = 32;
    localparam int ADDR_W  = 64;
    localparam int EXT_W   = 34;   // upper - lower + 1, signed
    localparam int MUL_W   = 32;   // operand width of the shared multiplier

    // Input tdata layout, lowest bit first
    localparam int AID_LSB   = 0;
    localparam int BASE_LSB  = AID_LSB + AID_W;
    localparam int SIZE_LSB  = BASE_LSB + BASE_W;
    localparam int DCNT_LSB  = SIZE_LSB + SIZE_W;
    localparam int DSEL_LSB  = DCNT_LSB + DCNT_W;
    localparam int LOWER_LSB = DSEL_LSB + DSEL_W;
    localparam int UPPER_LSB = LOWER_LSB + BOUND_W;
    localparam int INDEX_LSB = UPPER_LSB + BOUND_W;
    localparam int S_USED_W  = INDEX_LSB + IDX_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int M_USED_W  = AID_W + ADDR_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Item kinds carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_HEADER = 2'd0,
        CMD_BOUNDS = 2'd1,
        CMD_INDEX  = 2'd2
    } cmd_t;

    // Per-array header entry
    typedef struct packed {
        logic [DCNT_W-1:0] dim_count;
        logic [SIZE_W-1:0] elem_size;
        logic [BASE_W-1:0] base_addr;
    } hdr_t;

    // Per-dimension entry
    typedef struct packed {
        logic signed [EXT_W-1:0]   extent;
        logic signed [BOUND_W-1:0] lower;
    } dim_t;

endpackage

// ===== rtl/madg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module madg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/madg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madg_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module madg_mul
    import madg_pkg::*;
(
    input  logic               aclk,
    input  logic [MUL_W-1:0]   op_a,
    input  logic [MUL_W-1:0]   op_b,
    output logic [2*MUL_W-1:0] prod
);

    // Register the full product every cycle
    always_ff @(posedge aclk) begin
        prod <= op_a * op_b;
    end

endmodule

// ===== rtl/multidim_array_address_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multidim_array_address_generator
// Row-major address generator for multi-dimensional arrays held in on-chip
// descriptor tables.
// ----------------------------------------------------------------------------
// Header and bounds items are taken whenever the generator is idle and written
// straight into the header and dimension RAMs. An index item goes through a
// RAM read and three passes through the single shared 32 x 32 multiplier that
// forms acc * extent modulo 2^64; no new item is taken until it is done.
// The index marked last then goes on to the scale by element size (two more
// multiplier passes) and the load of the output register, which waits while
// the output stays stalled. The descriptor tables power up undefined
// and need no clearing pass; referencing an unwritten descriptor returns
// undefined addresses. array_id is taken modulo MAX_ARRAYS for table access.
// ----------------------------------------------------------------------------
module multidim_array_address_generator
    import madg_pkg::*;
#(
    parameter int MAX_ARRAYS = 16,
    parameter int MAX_DIMS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // array_id, base_addr, elem_size, dim_count, dim_sel, lower_bound,
    // upper_bound, index_value, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    // cmd
    input  logic [CMD_W-1:0]     s_tuser,
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // array_id_out, address, zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_W  = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int DPOS_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DDEPTH  = MAX_ARRAYS * MAX_DIMS;
    localparam int DADDR_W = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int AID_N   = 1 << AID_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_S0,
        ST_S1,
        ST_S2,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [ADDR_W-1:0]     acc_reg;
    logic [DPOS_W-1:0]     dim_pos_reg;
    logic                  m_valid_reg;
    logic [AID_W-1:0]      m_aid_reg;
    logic [ADDR_W-1:0]     m_addr_reg;

    logic [AID_W-1:0]      aid_reg;
    logic                  last_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [EXT_W-1:0]      ext_reg;
    logic [BASE_W-1:0]     base_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [ADDR_W-1:0]     term_reg;
    logic [ADDR_W-1:0]     lo_reg;
    logic [MUL_W-1:0]      hi_reg;

    // Input field views
    logic [AID_W-1:0]      in_aid;
    logic [DSEL_W-1:0]     in_dsel;
    logic signed [BOUND_W-1:0] in_lower;
    logic signed [BOUND_W-1:0] in_upper;
    cmd_t                  in_cmd;
    logic                  s_accept;

    assign in_aid   = s_tdata[AID_LSB +: AID_W];
    assign in_dsel  = s_tdata[DSEL_LSB +: DSEL_W];
    assign in_lower = s_tdata[LOWER_LSB +: BOUND_W];
    assign in_upper = s_tdata[UPPER_LSB +: BOUND_W];
    assign in_cmd   = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Array number to table slot, modulo MAX_ARRAYS
    logic [SLOT_W-1:0] slot_lut [AID_N];
    for (genvar g = 0; g < AID_N; g++) begin : g_slot
        assign slot_lut[g] = SLOT_W'(g % MAX_ARRAYS);
    end

    logic [SLOT_W-1:0] in_slot;
    assign in_slot = slot_lut[in_aid];

    // Header RAM
    logic hdr_we;
    logic hdr_re;
    hdr_t hdr_wdata;
    hdr_t hdr_rdata;

    assign hdr_wdata.base_addr = s_tdata[BASE_LSB +: BASE_W];
    assign hdr_wdata.elem_size = s_tdata[SIZE_LSB +: SIZE_W];
    assign hdr_wdata.dim_count = s_tdata[DCNT_LSB +: DCNT_W];

    madg_ram #(
        .WIDTH ($bits(hdr_t)),
        .DEPTH (MAX_ARRAYS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (hdr_we),
        .waddr (in_slot),
        .wdata (hdr_wdata),
        .re    (hdr_re),
        .raddr (in_slot),
        .rdata (hdr_rdata)
    );

    // Dimension RAM
    logic                 dim_we;
    logic                 dim_re;
    logic [DADDR_W-1:0]   dim_waddr;
    logic [DADDR_W-1:0]   dim_raddr;
    dim_t                 dim_wdata;
    dim_t                 dim_rdata;

    assign dim_waddr = DADDR_W'(32'(in_slot) * 32'(MAX_DIMS) + 32'(in_dsel));
    assign dim_raddr = DADDR_W'(32'(in_slot) * 32'(MAX_DIMS) + 32'(dim_pos_reg));
    assign dim_wdata.lower  = in_lower;
    assign dim_wdata.extent = EXT_W'(in_upper) - EXT_W'(in_lower) + EXT_W'(1);

    madg_ram #(
        .WIDTH ($bits(dim_t)),
        .DEPTH (DDEPTH)
    ) u_dim_ram (
        .aclk  (aclk),
        .we    (dim_we),
        .waddr (dim_waddr),
        .wdata (dim_wdata),
        .re    (dim_re),
        .raddr (dim_raddr),
        .rdata (dim_rdata)
    );

    // Decode accepted items into table writes and reads
    always_comb begin
        hdr_we = 1'b0;
        dim_we = 1'b0;
        hdr_re = 1'b0;
        dim_re = 1'b0;
        if (s_accept) begin
            unique case (in_cmd)
                CMD_HEADER: hdr_we = 1'b1;
                CMD_BOUNDS: dim_we = (32'(in_dsel) < 32'(MAX_DIMS));
                CMD_INDEX: begin
                    hdr_re = 1'b1;
                    dim_re = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Sign-extended extent, split in 32-bit halves
    logic [ADDR_W-1:0] ext_sx;
    assign ext_sx = {{(ADDR_W - EXT_W){ext_reg[EXT_W-1]}}, ext_reg};

    // Shared multiplier operand selection
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;

    always_comb begin
        mul_a = acc_reg[MUL_W-1:0];
        mul_b = '0;
        case (state_reg)
            ST_RD: mul_b = dim_rdata.extent[MUL_W-1:0];
            ST_M1: mul_b = ext_sx[ADDR_W-1:MUL_W];
            ST_M2: begin
                mul_a = acc_reg[ADDR_W-1:MUL_W];
                mul_b = ext_sx[MUL_W-1:0];
            end
            ST_S0: mul_b = MUL_W'(size_reg);
            ST_S1: begin
                mul_a = acc_reg[ADDR_W-1:MUL_W];
                mul_b = MUL_W'(size_reg);
            end
            default: ;
        endcase
    end

    madg_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    logic [ADDR_W-1:0] idx_sx;
    logic [ADDR_W-1:0] lower_sx;
    assign idx_sx   = {{(ADDR_W - IDX_W){idx_reg[IDX_W-1]}}, idx_reg};
    assign lower_sx = {{(ADDR_W - BOUND_W){dim_rdata.lower[BOUND_W-1]}}, dim_rdata.lower};

    // Sequencer: accumulate one index, then scale and emit on the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            dim_pos_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one is loaded now
            if (m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (in_cmd == CMD_INDEX)) begin
                        aid_reg   <= in_aid;
                        last_reg  <= s_tlast;
                        idx_reg   <= s_tdata[INDEX_LSB +: IDX_W];
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    // Table data is in; start acc_lo * ext_lo
                    ext_reg   <= dim_rdata.extent;
                    base_reg  <= hdr_rdata.base_addr;
                    size_reg  <= hdr_rdata.elem_size;
                    term_reg  <= idx_sx - lower_sx;
                    state_reg <= ST_M1;
                end
                ST_M1: begin
                    lo_reg    <= mul_p + term_reg;
                    state_reg <= ST_M2;
                end
                ST_M2: begin
                    hi_reg    <= mul_p[MUL_W-1:0];
                    state_reg <= ST_M3;
                end
                ST_M3: begin
                    acc_reg <= lo_reg + {hi_reg + mul_p[MUL_W-1:0], {MUL_W{1'b0}}};
                    if (last_reg) begin
                        dim_pos_reg <= '0;
                        state_reg   <= ST_S0;
                    end else begin
                        if (dim_pos_reg == DPOS_W'(MAX_DIMS - 1)) begin
                            dim_pos_reg <= '0;
                        end else begin
                            dim_pos_reg <= dim_pos_reg + DPOS_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_S0: begin
                    state_reg <= ST_S1;
                end
                ST_S1: begin
                    lo_reg    <= mul_p + ADDR_W'(base_reg);
                    state_reg <= ST_S2;
                end
                ST_S2: begin
                    lo_reg    <= lo_reg + {mul_p[MUL_W-1:0], {MUL_W{1'b0}}};
                    acc_reg   <= '0;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_aid_reg   <= aid_reg;
                        m_addr_reg  <= lo_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, m_addr_reg, m_aid_reg};

endmodule
